FILE: rtl/rgbfade_pkg.sv
// Shared types, constants and helper functions for the five-channel LED fader.
// Used by rgbfade_target, rgb_cw_led_target_fader and the testbench; depends on nothing else.
`timescale 1ns / 1ps

package rgbfade_pkg;

	localparam int CHANNELS = 5;
	localparam int LEVEL_W  = 10;
	localparam int CFG_W    = 8;
	localparam int IDX_W    = 3;
	localparam int PROD_W   = 2 * CFG_W;

	localparam logic [PROD_W-1:0]  MAX_LEVEL = 16'd1023;
	localparam logic [LEVEL_W:0]   FADE_STEP = 11'd8;
	localparam logic [CFG_W-1:0]   MIX_FULL  = 8'd255;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_POWER      = 3'd0;
	localparam logic [IDX_W-1:0] REG_RED        = 3'd1;
	localparam logic [IDX_W-1:0] REG_GREEN      = 3'd2;
	localparam logic [IDX_W-1:0] REG_BLUE       = 3'd3;
	localparam logic [IDX_W-1:0] REG_RGB_BRIGHT = 3'd4;
	localparam logic [IDX_W-1:0] REG_WHITE_MIX  = 3'd5;
	localparam logic [IDX_W-1:0] REG_WHITE_BRT  = 3'd6;

	// Channel positions within a level vector.
	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;
	localparam int CH_WARM  = 3;
	localparam int CH_COOL  = 4;

	typedef logic [LEVEL_W-1:0] level_t;
	typedef logic [CHANNELS-1:0][LEVEL_W-1:0] levels_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] index;
		logic [CFG_W-1:0] data;
	} cfg_write_t;

	// Clamps a brightness product to the top drive level.
	function automatic level_t clamp_level(logic [PROD_W-1:0] prod);
		level_t res;
		if (prod > MAX_LEVEL) begin
			res = MAX_LEVEL[LEVEL_W-1:0];
		end else begin
			res = prod[LEVEL_W-1:0];
		end
		return res;
	endfunction

	// One fade tick: move by a step towards the target, or land on it when close.
	function automatic level_t fade_level(level_t cur, level_t tgt);
		logic [LEVEL_W:0] cur_up;
		logic [LEVEL_W:0] tgt_up;
		level_t           res;
		cur_up = {1'b0, cur} + FADE_STEP;
		tgt_up = {1'b0, tgt} + FADE_STEP;
		if (cur_up < {1'b0, tgt}) begin
			res = cur_up[LEVEL_W-1:0];
		end else if (tgt_up < {1'b0, cur}) begin
			res = cur - FADE_STEP[LEVEL_W-1:0];
		end else begin
			res = tgt;
		end
		return res;
	endfunction

endpackage

FILE: rtl/rgbfade_target.sv
// Configuration registers and registered target levels for the LED fader.
// Depends on rgbfade_pkg.
`timescale 1ns / 1ps

module rgbfade_target
	import rgbfade_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_write_t cfg,
	output levels_t    target
);

	logic [1:0]       power_q;
	logic [CFG_W-1:0] red_q;
	logic [CFG_W-1:0] green_q;
	logic [CFG_W-1:0] blue_q;
	logic [CFG_W-1:0] rgb_bright_q;
	logic [CFG_W-1:0] mix_q;
	logic [CFG_W-1:0] white_bright_q;
	levels_t          target_q;

	logic [CFG_W-1:0] warm_share;
	levels_t          target_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_q        <= '0;
			red_q          <= '0;
			green_q        <= '0;
			blue_q         <= '0;
			rgb_bright_q   <= '0;
			mix_q          <= '0;
			white_bright_q <= '0;
		end else if (cfg.we) begin
			unique case (cfg.index)
				REG_POWER:      power_q        <= cfg.data[1:0];
				REG_RED:        red_q          <= cfg.data;
				REG_GREEN:      green_q        <= cfg.data;
				REG_BLUE:       blue_q         <= cfg.data;
				REG_RGB_BRIGHT: rgb_bright_q   <= cfg.data;
				REG_WHITE_MIX:  mix_q          <= cfg.data;
				REG_WHITE_BRT:  white_bright_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// A mix beyond full gives no warm light rather than a wrapped share.
	assign warm_share = (mix_q > MIX_FULL) ? '0 : (MIX_FULL - mix_q);

	always_comb begin
		target_d = '0;
		if (power_q[0]) begin
			target_d[CH_RED]   = clamp_level(red_q * rgb_bright_q);
			target_d[CH_GREEN] = clamp_level(green_q * rgb_bright_q);
			target_d[CH_BLUE]  = clamp_level(blue_q * rgb_bright_q);
		end
		if (power_q[1]) begin
			target_d[CH_WARM] = clamp_level(warm_share * white_bright_q);
			target_d[CH_COOL] = clamp_level(mix_q * white_bright_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else begin
			target_q <= target_d;
		end
	end

	assign target = target_q;

endmodule

FILE: rtl/rgb_cw_led_target_fader.sv
// Top level of the five-channel LED fader: request pipeline and level state.
// Depends on rgbfade_pkg and rgbfade_target.
`timescale 1ns / 1ps

// Five-channel fader for red, green, blue, warm white and cool white. Each
// request either takes one fade tick (advance high) or simply reports the
// levels; every request gives exactly one result carrying all five levels and
// a settled flag. Requests are taken one per clock cycle unless a result waits
// untaken on the output, each passing through one input register, then the fade
// compare-and-step logic into the level and result registers. Target levels
// are registered from the configuration registers, so a request should follow
// a configuration write by at least one cycle.

module rgb_cw_led_target_fader
	import rgbfade_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               advance,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [LEVEL_W-1:0] red_out,
	output logic [LEVEL_W-1:0] green_out,
	output logic [LEVEL_W-1:0] blue_out,
	output logic [LEVEL_W-1:0] warm_out,
	output logic [LEVEL_W-1:0] cool_out,
	output logic               settled
);

	cfg_write_t cfg;
	levels_t    target;

	logic    valid_s1;
	logic    advance_s1;
	logic    out_valid_q;
	logic    settled_q;
	levels_t level_q;

	logic    out_free;
	logic    move_s1;
	levels_t level_d;

	assign cfg = '{we: cfg_we, index: cfg_index, data: cfg_data};

	rgbfade_target u_target (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.target (target)
	);

	assign out_free = !out_valid_q || out_ready;
	assign move_s1  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			advance_s1 <= advance;
		end
	end

	always_comb begin
		for (int ch = 0; ch < CHANNELS; ch++) begin
			level_d[ch] = advance_s1 ? fade_level(level_q[ch], target[ch]) : level_q[ch];
		end
	end

	// The level state doubles as the result payload: it only changes when a
	// new result replaces the one on the output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			level_q     <= '0;
			settled_q   <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
			if (move_s1) begin
				level_q   <= level_d;
				settled_q <= (level_d == target);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign red_out   = level_q[CH_RED];
	assign green_out = level_q[CH_GREEN];
	assign blue_out  = level_q[CH_BLUE];
	assign warm_out  = level_q[CH_WARM];
	assign cool_out  = level_q[CH_COOL];
	assign settled   = settled_q;

`ifndef SYNTHESIS
	// Levels only move when an advancing request passes into the result register.
	a_level_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(move_s1 && advance_s1) |=> $stable(level_q))
		else $error("levels changed without an advancing request");

	// The input side only stalls while a request is held in the input register.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled without a blocked request");

	// An accepted request is always held in the input register on the next cycle.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("accepted request lost");

	// A request leaving the input register always produces a visible result.
	a_move_result: assert property (@(posedge clk) disable iff (!arst_n)
		move_s1 |=> out_valid_q)
		else $error("result missing after request moved");
`endif

endmodule

FILE: sim/tb_rgb_cw_led_target_fader.sv
// Self-checking testbench for rgb_cw_led_target_fader: directed fades, then random scenes.
// It predicts each request's levels and settled flag and compares every result in order.
// Depends on rgbfade_pkg and the fader RTL.
`timescale 1ns / 1ps

module tb_rgb_cw_led_target_fader;
	import rgbfade_pkg::*;

	localparam int FADE_TICK       = 8;
	localparam int LEVEL_CAP       = 1023;
	localparam int MIX_SCALE       = 255;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int MAX_REPORTS     = 10;
	localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;

	typedef struct {
		levels_t lv;
		logic    settled;
	} fade_result_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cfg_we    = 1'b0;
	logic [IDX_W-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]   cfg_data  = '0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	logic               advance   = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [LEVEL_W-1:0] red_out, green_out, blue_out, warm_out, cool_out;
	logic               settled;

	fade_result_t     expected_levels[$];
	logic [CFG_W-1:0] shade_reg [0:6];
	int               level_now [CHANNELS];
	int               send_idle_pct = 0;
	int               recv_idle_pct = 0;
	int               mismatches    = 0;
	logic             holding       = 1'b0;
	event             hold_off_ev;

	rgb_cw_led_target_fader u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.advance   (advance),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.warm_out  (warm_out),
		.cool_out  (cool_out),
		.settled   (settled)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	function automatic int capped(input int v);
		return (v > LEVEL_CAP) ? LEVEL_CAP : v;
	endfunction

	// Works out the targets from the current registers, takes one tick if asked,
	// and returns the levels and settled flag that the request should report.
	function automatic fade_result_t predict_step(input logic adv);
		int           tgt [CHANNELS];
		int           warm_share;
		fade_result_t r;
		foreach (tgt[ch]) tgt[ch] = 0;
		if (shade_reg[REG_POWER][0]) begin
			tgt[CH_RED]   = capped(int'(shade_reg[REG_RED]) * int'(shade_reg[REG_RGB_BRIGHT]));
			tgt[CH_GREEN] = capped(int'(shade_reg[REG_GREEN]) * int'(shade_reg[REG_RGB_BRIGHT]));
			tgt[CH_BLUE]  = capped(int'(shade_reg[REG_BLUE]) * int'(shade_reg[REG_RGB_BRIGHT]));
		end
		if (shade_reg[REG_POWER][1]) begin
			warm_share = (int'(shade_reg[REG_WHITE_MIX]) > MIX_SCALE) ? 0
				: MIX_SCALE - int'(shade_reg[REG_WHITE_MIX]);
			tgt[CH_WARM] = capped(warm_share * int'(shade_reg[REG_WHITE_BRT]));
			tgt[CH_COOL] = capped(int'(shade_reg[REG_WHITE_MIX]) * int'(shade_reg[REG_WHITE_BRT]));
		end
		r.settled = 1'b1;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			if (adv) begin
				if (level_now[ch] + FADE_TICK < tgt[ch]) begin
					level_now[ch] += FADE_TICK;
				end else if (tgt[ch] + FADE_TICK < level_now[ch]) begin
					level_now[ch] -= FADE_TICK;
				end else begin
					level_now[ch] = tgt[ch];
				end
			end
			if (level_now[ch] != tgt[ch]) begin
				r.settled = 1'b0;
			end
			r.lv[ch] = level_t'(level_now[ch]);
		end
		return r;
	endfunction

	function automatic logic [CFG_W-1:0] pick_shade();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			2: return CFG_W'($urandom_range(0, 15));
			default: return CFG_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("%0t: %s", $realtime, msg);
		end
	endtask

	// Result checker: every accepted result is matched against the oldest request.
	always @(posedge clk) begin
		fade_result_t exp_r;
		levels_t      got;
		logic         bad;
		if (arst_n && out_valid && out_ready) begin
			got[CH_RED]   = red_out;
			got[CH_GREEN] = green_out;
			got[CH_BLUE]  = blue_out;
			got[CH_WARM]  = warm_out;
			got[CH_COOL]  = cool_out;
			if (expected_levels.size() == 0) begin
				note_mismatch($sformatf("result with no request outstanding: levels %p settled %0b",
					got, settled));
			end else begin
				exp_r = expected_levels.pop_front();
				bad = 1'b0;
				for (int ch = 0; ch < CHANNELS; ch++) begin
					if (got[ch] !== exp_r.lv[ch]) bad = 1'b1;
				end
				if (settled !== exp_r.settled) bad = 1'b1;
				if (bad) begin
					note_mismatch($sformatf(
						"level mismatch: expected r%0d g%0d b%0d w%0d c%0d s%0b, got r%0d g%0d b%0d w%0d c%0d s%0b",
						exp_r.lv[CH_RED], exp_r.lv[CH_GREEN], exp_r.lv[CH_BLUE],
						exp_r.lv[CH_WARM], exp_r.lv[CH_COOL], exp_r.settled,
						red_out, green_out, blue_out, warm_out, cool_out, settled));
				end
			end
		end
	end

	always @(negedge clk) begin
		if (holding) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Long receiver hold-off, timed here so that the sender keeps pushing meanwhile.
	initial begin
		forever begin
			@(hold_off_ev);
			holding = 1'b1;
			repeat (HOLD_OFF_CYCLES) @(posedge clk);
			holding = 1'b0;
		end
	end

	task automatic send_request(input logic adv);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			advance  <= 1'($urandom_range(0, 1));
			@(negedge clk);
		end
		in_valid <= 1'b1;
		advance  <= adv;
		do @(posedge clk); while (!in_ready);
		expected_levels.push_back(predict_step(adv));
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_levels.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx != REG_SPARE) begin
			shade_reg[idx] = (idx == REG_POWER) ? (val & 8'h03) : val;
		end
	endtask

	task automatic configure_scene(input logic [CFG_W-1:0] power, input logic [CFG_W-1:0] red,
			input logic [CFG_W-1:0] green, input logic [CFG_W-1:0] blue,
			input logic [CFG_W-1:0] rgb_brt, input logic [CFG_W-1:0] mix,
			input logic [CFG_W-1:0] white_brt);
		write_reg(REG_POWER, power);
		write_reg(REG_RED, red);
		write_reg(REG_GREEN, green);
		write_reg(REG_BLUE, blue);
		write_reg(REG_RGB_BRIGHT, rgb_brt);
		write_reg(REG_WHITE_MIX, mix);
		write_reg(REG_WHITE_BRT, white_brt);
		// Targets are registered after the configuration registers take the write.
		@(negedge clk);
	endtask

	task automatic random_scene();
		if ($urandom_range(0, 3) == 0) begin
			write_reg(REG_SPARE, CFG_W'($urandom));
		end
		configure_scene(CFG_W'($urandom_range(0, 255)), pick_shade(), pick_shade(), pick_shade(),
			pick_shade(), pick_shade(), pick_shade());
	endtask

	// Everything off after reset, so every channel already sits on its target;
	// a write to the unused index must change nothing.
	task automatic test_idle_after_reset();
		send_request(1'b0);
		send_request(1'b1);
		wait_idle();
		write_reg(REG_SPARE, 8'hFF);
		send_request(1'b1);
	endtask

	// Products far above the top level are clamped; a full mix leaves warm at zero.
	task automatic test_full_scale();
		wait_idle();
		configure_scene(8'h03, 8'hFF, 8'h00, 8'h04, 8'hFF, 8'hFF, 8'hFF);
		repeat (5) send_request(1'b1);
		send_request(1'b0);
	endtask

	task automatic test_warm_only();
		wait_idle();
		configure_scene(8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF);
		repeat (4) send_request(1'b1);
	endtask

	task automatic test_power_off();
		wait_idle();
		configure_scene(8'hFC, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'hFF);
		repeat (5) send_request(1'b1);
		send_request(1'b0);
	endtask

	task automatic test_small_targets();
		wait_idle();
		configure_scene(8'h03, 8'h01, 8'h02, 8'h03, 8'h05, 8'h64, 8'h00);
		repeat (5) send_request(1'b1);
	endtask

	task automatic test_output_hold();
		wait_idle();
		random_scene();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		-> hold_off_ev;
		repeat (40) send_request(1'($urandom_range(0, 1)));
	endtask

	task automatic test_random_fades(input int count, input int send_pct, input int recv_pct);
		int sent;
		int burst;
		sent = 0;
		while (sent < count) begin
			wait_idle();
			send_idle_pct = send_pct;
			recv_idle_pct = recv_pct;
			random_scene();
			burst = $urandom_range(30, 160);
			repeat (burst) send_request($urandom_range(0, 99) < 85);
			sent += burst;
		end
	endtask

	initial begin
		foreach (shade_reg[i]) shade_reg[i] = '0;
		foreach (level_now[ch]) level_now[ch] = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_idle_after_reset();
		test_full_scale();
		test_warm_only();
		test_power_off();
		test_small_targets();
		test_output_hold();
		test_random_fades(580, 24, 62);
		test_random_fades(580, 62, 24);
		test_random_fades(580, 0, 0);

		wait_idle();
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
